[hdl/rsp_pkg.sv]
// ---------------------------------------------------------------------------
// rsp_pkg
// Shared types and constants of the stream parser.
// ---------------------------------------------------------------------------
package rsp_pkg;

  typedef enum logic [2:0] {
    PH_IDLE = 3'd0,
    PH_STR  = 3'd1,
    PH_INT  = 3'd2,
    PH_LEN  = 3'd3,
    PH_CNT  = 3'd4,
    PH_DATA = 3'd5,
    PH_SKIP = 3'd6
  } phase_t;

  localparam logic [2:0] EV_PAY  = 3'd0;
  localparam logic [2:0] EV_END  = 3'd1;
  localparam logic [2:0] EV_INT  = 3'd2;
  localparam logic [2:0] EV_NULL = 3'd3;
  localparam logic [2:0] EV_ARR  = 3'd4;
  localparam logic [2:0] EV_ERR  = 3'd5;
  localparam logic [2:0] EV_BULK = 3'd6;

  localparam logic [1:0] KIND_SIMPLE = 2'd0;
  localparam logic [1:0] KIND_ERROR  = 2'd1;
  localparam logic [1:0] KIND_BULK   = 2'd2;

  localparam logic [2:0] ERR_NONE  = 3'd0;
  localparam logic [2:0] ERR_TYPE  = 3'd1;
  localparam logic [2:0] ERR_INT   = 3'd2;
  localparam logic [2:0] ERR_LEN   = 3'd3;
  localparam logic [2:0] ERR_CNT   = 3'd4;
  localparam logic [2:0] ERR_LIMIT = 3'd5;

  localparam logic REG_MAX_BULK  = 1'b0;
  localparam logic REG_MAX_COUNT = 1'b1;

  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  typedef struct packed {
    logic [7:0] in_byte;
  } in_item_t;

  typedef struct packed {
    logic [2:0]         event_res;
    logic [1:0]         string_kind;
    logic [7:0]         payload;
    logic signed [63:0] number;
    logic [3:0]         nesting;
    logic               message_done;
    logic [2:0]         error_code;
    logic               last;
  } out_item_t;

endpackage

[hdl/rsp_stream_if.sv]
// ---------------------------------------------------------------------------
// rsp_stream_if
// Valid/ready channel carrying one payload of a chosen type.
// ---------------------------------------------------------------------------
interface rsp_stream_if #(parameter type T = logic [7:0]);
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

[hdl/resp_stream_parser_core.sv]
// ---------------------------------------------------------------------------
// resp_stream_parser_core
// Byte-serial tokenizer for the RESP2 request protocol.
// ---------------------------------------------------------------------------
// One byte is taken per clock while the input is ready. Each byte is decoded
// by the parse state register and its next-state logic, and gives zero, one
// or two events. Events go to a registered two-entry output queue and leave
// in the cycle after the byte transfer at the earliest. The input is ready
// while the queue is empty or is handing over its only event in the same
// cycle, so with a free-running sink one byte is transferred every cycle.
// The exception is a byte that gives two events (a lone CR in a string
// followed by another character): it fills the queue, and the input is held
// while the first event drains. The sticky error state swallows all later
// bytes until reset. Array counts are held in a MAX_DEPTH-entry stack.
module resp_stream_parser_core #(
  parameter int MAX_DEPTH  = 8,
  parameter int COUNT_BITS = 32
) (
  input  logic clk,
  input  logic rst,
  rsp_stream_if.sink   in_ch,
  rsp_stream_if.source out_ch,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [31:0] cfg_data
);
  import rsp_pkg::*;

  localparam int DW = $clog2(MAX_DEPTH + 1);
  localparam int IW = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;

  // configuration
  logic [31:0] max_bulk, max_count;
  always_ff @(posedge clk) begin
    if (rst) begin
      max_bulk  <= 32'd536870912;
      max_count <= 32'd1048576;
    end else if (cfg_we) begin
      if (cfg_index == REG_MAX_BULK) max_bulk <= cfg_data;
      else max_count <= cfg_data;
    end
  end

  // parse state
  phase_t            phase, phase_next;
  logic [1:0]        kind, kind_next;
  logic              crp, crp_next;
  logic [63:0]       acc, acc_next;
  logic              neg, neg_next, dig, dig_next;
  logic [31:0]       bleft, bleft_next;
  logic              skip2, skip2_next;
  logic [DW-1:0]     depth, depth_next;
  logic [COUNT_BITS-1:0] elem [MAX_DEPTH];
  logic [2:0]        err, err_next;

  // stack update requests
  logic              push;
  logic [COUNT_BITS-1:0] push_val;
  logic              retire;

  // results of this byte
  out_item_t r0, r1;
  logic      v0, v1;

  // output queue
  out_item_t q [2];
  logic [1:0] cnt;

  logic take;
  assign in_ch.ready = (cnt == 2'd0) || (cnt == 2'd1 && out_ch.ready);
  assign take = in_ch.valid && in_ch.ready;

  // completion walk: find how far the stack retires, bounded by depth
  logic [DW-1:0] done_depth;
  logic          done_top;
  always_comb begin
    done_depth = depth;
    done_top   = 1'b1;
    for (int k = MAX_DEPTH - 1; k >= 0; k--) begin
      if (k < int'(depth)) begin
        if (done_top && elem[k] > COUNT_BITS'(1)) begin
          done_top = 1'b0;
        end
        if (done_top) done_depth = DW'(k);
      end
    end
    if (!done_top) begin
      done_depth = depth;
      for (int k = 0; k < MAX_DEPTH; k++) begin
        if (k < int'(depth) && elem[k] > COUNT_BITS'(1)) done_depth = DW'(k + 1);
      end
    end
  end

  function automatic out_item_t mk(input logic [2:0] ev, input logic [1:0] kd,
                                   input logic [7:0] pl, input logic [63:0] nm,
                                   input logic [3:0] ns, input logic [2:0] ec);
    out_item_t o;
    o.event_res = ev; o.string_kind = kd; o.payload = pl; o.number = nm;
    o.nesting = ns; o.message_done = 1'b0; o.error_code = ec; o.last = 1'b0;
    return o;
  endfunction

  logic [7:0]  b;
  logic [3:0]  nest;
  logic [2:0]  ncode;
  logic [63:0] d, lim, val, mul10;
  logic        ovf;

  always_comb begin
    b = in_ch.data.in_byte;
    nest = 4'(depth);
    phase_next = phase; kind_next = kind; crp_next = crp; acc_next = acc;
    neg_next = neg; dig_next = dig; bleft_next = bleft; skip2_next = skip2;
    depth_next = depth; err_next = err;
    push = 1'b0; push_val = '0; retire = 1'b0;
    v0 = 1'b0; v1 = 1'b0;
    r0 = mk(EV_PAY, KIND_SIMPLE, 8'd0, 64'd0, nest, ERR_NONE);
    r1 = r0;
    ncode = (phase == PH_INT) ? ERR_INT : (phase == PH_LEN) ? ERR_LEN : ERR_CNT;
    d = {56'd0, b - CH_ZERO};
    lim = neg ? 64'h8000000000000000 : 64'h7FFFFFFFFFFFFFFF;
    mul10 = {acc[60:0], 3'b000} + {acc[62:0], 1'b0};
    ovf = (acc > 64'h0CCCCCCCCCCCCCCC) || (mul10 > lim - d);
    val = neg ? (64'd0 - acc) : acc;
    if (err == ERR_NONE) begin
      unique case (phase) inside
        PH_IDLE: begin
          crp_next = 1'b0; acc_next = '0; neg_next = 1'b0; dig_next = 1'b0;
          if (b == CH_PLUS || b == CH_MINUS) begin
            kind_next = (b == CH_MINUS) ? KIND_ERROR : KIND_SIMPLE;
            phase_next = PH_STR;
          end else if (b == CH_COLON) phase_next = PH_INT;
          else if (b == CH_DOLLAR) phase_next = PH_LEN;
          else if (b == CH_STAR) phase_next = PH_CNT;
          else begin
            err_next = ERR_TYPE; v0 = 1'b1;
            r0 = mk(EV_ERR, KIND_SIMPLE, 8'd0, 64'd0, nest, ERR_TYPE);
          end
        end
        PH_STR: begin
          if (crp && b == CH_LF) begin
            crp_next = 1'b0; phase_next = PH_IDLE; v0 = 1'b1; retire = 1'b1;
            r0 = mk(EV_END, kind, 8'd0, 64'd0, nest, ERR_NONE);
          end else begin
            crp_next = (b == CH_CR);
            if (crp) begin
              v0 = 1'b1;
              r0 = mk(EV_PAY, kind, CH_CR, 64'd0, nest, ERR_NONE);
              if (b != CH_CR) begin
                v1 = 1'b1;
                r1 = mk(EV_PAY, kind, b, 64'd0, nest, ERR_NONE);
              end
            end else if (b != CH_CR) begin
              v0 = 1'b1;
              r0 = mk(EV_PAY, kind, b, 64'd0, nest, ERR_NONE);
            end
          end
        end
        PH_INT, PH_LEN, PH_CNT: begin
          if (crp) begin
            crp_next = 1'b0;
            if (b != CH_LF || !dig) begin
              err_next = ncode; phase_next = PH_IDLE; v0 = 1'b1;
              r0 = mk(EV_ERR, KIND_SIMPLE, 8'd0, 64'd0, nest, ncode);
            end else begin
              phase_next = PH_IDLE; v0 = 1'b1;
              if (phase == PH_INT) begin
                retire = 1'b1;
                r0 = mk(EV_INT, KIND_SIMPLE, 8'd0, val, nest, ERR_NONE);
              end else if (neg && acc == 64'd1) begin
                retire = 1'b1;
                r0 = mk(EV_NULL, KIND_SIMPLE, 8'd0, 64'd0, nest, ERR_NONE);
              end else if (neg && acc != 64'd0) begin
                err_next = ncode;
                r0 = mk(EV_ERR, KIND_SIMPLE, 8'd0, 64'd0, nest, ncode);
              end else if (phase == PH_LEN) begin
                if (acc > {32'd0, max_bulk}) begin
                  err_next = ERR_LIMIT;
                  r0 = mk(EV_ERR, KIND_SIMPLE, 8'd0, 64'd0, nest, ERR_LIMIT);
                end else begin
                  r0 = mk(EV_BULK, KIND_SIMPLE, 8'd0, acc, nest, ERR_NONE);
                  bleft_next = acc[31:0];
                  if (acc == 64'd0) begin
                    phase_next = PH_SKIP; skip2_next = 1'b1;
                  end else phase_next = PH_DATA;
                end
              end else begin
                if (acc > {32'd0, max_count} || (acc >> COUNT_BITS) != 64'd0
                    || (acc != 64'd0 && int'(depth) >= MAX_DEPTH)) begin
                  err_next = ERR_LIMIT;
                  r0 = mk(EV_ERR, KIND_SIMPLE, 8'd0, 64'd0, nest, ERR_LIMIT);
                end else if (acc == 64'd0) begin
                  retire = 1'b1;
                  r0 = mk(EV_ARR, KIND_SIMPLE, 8'd0, 64'd0, nest, ERR_NONE);
                end else begin
                  r0 = mk(EV_ARR, KIND_SIMPLE, 8'd0, acc, nest, ERR_NONE);
                  push = 1'b1; push_val = acc[COUNT_BITS-1:0];
                  depth_next = depth + DW'(1);
                end
              end
            end
          end else if (b == CH_CR) crp_next = 1'b1;
          else if (b == CH_MINUS && !neg && !dig) neg_next = 1'b1;
          else if (b >= CH_ZERO && b <= CH_NINE) begin
            if (ovf) begin
              err_next = ncode; phase_next = PH_IDLE; v0 = 1'b1;
              r0 = mk(EV_ERR, KIND_SIMPLE, 8'd0, 64'd0, nest, ncode);
            end else begin
              acc_next = mul10 + d; dig_next = 1'b1;
            end
          end else begin
            err_next = ncode; phase_next = PH_IDLE; v0 = 1'b1;
            r0 = mk(EV_ERR, KIND_SIMPLE, 8'd0, 64'd0, nest, ncode);
          end
        end
        PH_DATA: begin
          v0 = 1'b1;
          r0 = mk(EV_PAY, KIND_BULK, b, 64'd0, nest, ERR_NONE);
          if (bleft <= 32'd1) begin
            bleft_next = '0; phase_next = PH_SKIP; skip2_next = 1'b1;
          end else bleft_next = bleft - 32'd1;
        end
        PH_SKIP: begin
          if (skip2) skip2_next = 1'b0;
          else begin
            phase_next = PH_IDLE; v0 = 1'b1; retire = 1'b1;
            r0 = mk(EV_END, KIND_BULK, 8'd0, 64'd0, nest, ERR_NONE);
          end
        end
        default: phase_next = PH_IDLE;
      endcase
    end
    if (retire) begin
      r0.message_done = done_top;
      depth_next = done_depth;
    end
    if (v1) r1.last = 1'b1;
    else r0.last = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_IDLE; kind <= KIND_SIMPLE; crp <= 1'b0; acc <= '0;
      neg <= 1'b0; dig <= 1'b0; bleft <= '0; skip2 <= 1'b0;
      depth <= '0; err <= ERR_NONE;
    end else if (take) begin
      phase <= phase_next; kind <= kind_next; crp <= crp_next; acc <= acc_next;
      neg <= neg_next; dig <= dig_next; bleft <= bleft_next; skip2 <= skip2_next;
      depth <= depth_next; err <= err_next;
    end
  end

  // stack: push writes the new top, retire decrements the surviving top
  always_ff @(posedge clk) begin
    if (take && push) elem[IW'(depth)] <= push_val;
    else if (take && retire && done_depth != '0)
      elem[IW'(done_depth - DW'(1))] <= elem[IW'(done_depth - DW'(1))] - COUNT_BITS'(1);
  end

  // output queue: q[0] is the head
  logic pop;
  logic [1:0] nnew;
  assign pop  = out_ch.valid && out_ch.ready;
  assign nnew = take ? (2'(v0) + 2'(v1)) : 2'd0;
  always_ff @(posedge clk) begin
    if (rst) cnt <= '0;
    else cnt <= cnt - 2'(pop) + nnew;
  end
  // a byte is only taken when the queue is empty after this cycle's pop,
  // so new events always land at the head
  always_ff @(posedge clk) begin
    if (take && v0) begin
      q[0] <= r0;
      if (v1) q[1] <= r1;
    end else if (pop) q[0] <= q[1];
  end
  assign out_ch.valid = (cnt != 2'd0);
  assign out_ch.data  = q[0];

  // checks
  a_cnt_bound: assert property (@(posedge clk) disable iff (rst) cnt <= 2'd2)
    else $error("queue overfill");
  a_depth_bound: assert property (@(posedge clk) disable iff (rst)
    int'(depth) <= MAX_DEPTH) else $error("stack overflow");
  a_err_silent: assert property (@(posedge clk) disable iff (rst)
    (err != ERR_NONE && take) |=> ($stable(err) && $past(nnew) == 2'd0))
    else $error("output after sticky error");
  a_pair_str: assert property (@(posedge clk) disable iff (rst)
    (take && v1) |-> (phase == PH_STR && crp)) else $error("unexpected pair");
endmodule
